// ===== hdl/modbus_read_transaction_macros.svh =====
// ----------------------------------------------------------------------------
// Modbus read transaction: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef MODBUS_READ_TRANSACTION_MACROS_SVH
`define MODBUS_READ_TRANSACTION_MACROS_SVH

// condition holds in the same cycle
`define RDTX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define RDTX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rdtx_pkg.sv =====
// ----------------------------------------------------------------------------
// rdtx_pkg
// Shared constants, command type and CRC-16 byte update.
// ----------------------------------------------------------------------------
package rdtx_pkg;

  localparam int MAX_REGISTERS = 125;

  localparam logic [7:0]  FUNC_READ_HOLDING   = 8'h03;
  localparam logic [15:0] CRC_INIT            = 16'hFFFF;
  localparam logic [15:0] CRC_POLY            = 16'hA001;
  localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'd1;
  localparam logic [15:0] TIMEOUT_RESET       = 16'd1000;

  // input actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // result kinds; KIND_REQ in a command means a whole request frame
  localparam logic [1:0] KIND_REQ    = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HEADER  = 2'd1;
  localparam logic [1:0] ST_CRC     = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // register indexes
  localparam logic REG_SLAVE_ADDRESS = 1'b0;
  localparam logic REG_TIMEOUT       = 1'b1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;   // start register or data word
    logic [7:0]  addr;    // slave address of a request
    logic [6:0]  index;   // register count of a request or word index
    logic [1:0]  status;
  } cmd_t;

  typedef enum logic {BK_IDLE, BK_REQ} back_state_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/rdtx_front.sv =====
// ----------------------------------------------------------------------------
// rdtx_front
// Accepts items, tracks the exchange and queues commands for the back end.
// ----------------------------------------------------------------------------
module rdtx_front import rdtx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [15:0] start_register,
  input  logic [6:0]  register_count,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  slave_address,
  input  logic [15:0] timeout_ticks,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic        waiting, waiting_next;
  logic [7:0]  bytes_received, bytes_received_next;
  logic [7:0]  expected_length, expected_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic        header_bad, header_bad_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;

  logic        accept;
  logic [6:0]  cnt_c;
  logic [8:0]  p2;
  logic [8:0]  p1;
  logic [8:0]  n9;
  logic [7:0]  d;
  logic        in_body;

  assign full   = q_full;
  assign accept = push & ~q_full;

  assign p2      = {1'b0, bytes_received} + 9'd2;
  assign p1      = {1'b0, bytes_received} + 9'd1;
  assign n9      = {1'b0, expected_length};
  assign in_body = p2 < n9;
  assign d       = bytes_received - 8'd3;

  always_comb begin
    if (register_count == 7'd0) begin
      cnt_c = 7'd1;
    end else if (register_count > 7'(MAX_REGISTERS)) begin
      cnt_c = 7'(MAX_REGISTERS);
    end else begin
      cnt_c = register_count;
    end
  end

  always_comb begin
    waiting_next         = waiting;
    bytes_received_next  = bytes_received;
    expected_length_next = expected_length;
    running_crc_next     = running_crc;
    header_bad_next      = header_bad;
    held_byte_next       = held_byte;
    crc_low_byte_next    = crc_low_byte;
    elapsed_ticks_next   = elapsed_ticks;
    q_push               = 1'b0;
    q_cmd                = '0;
    if (accept) begin
      case (action)
        ACT_START: begin
          if (!waiting) begin
            q_push               = 1'b1;
            q_cmd.kind           = KIND_REQ;
            q_cmd.value          = start_register;
            q_cmd.addr           = slave_address;
            q_cmd.index          = cnt_c;
            waiting_next         = 1'b1;
            bytes_received_next  = 8'd0;
            expected_length_next = 8'd5 + {cnt_c, 1'b0};
            running_crc_next     = CRC_INIT;
            header_bad_next      = 1'b0;
            held_byte_next       = 8'd0;
            crc_low_byte_next    = 8'd0;
            elapsed_ticks_next   = 16'd0;
          end
        end
        ACT_BYTE: begin
          if (waiting) begin
            if (in_body) begin
              running_crc_next = crc_update(running_crc, rx_byte);
            end
            if (bytes_received == 8'd0 && rx_byte != slave_address) begin
              header_bad_next = 1'b1;
            end
            if (bytes_received == 8'd1 && rx_byte != FUNC_READ_HOLDING) begin
              header_bad_next = 1'b1;
            end
            bytes_received_next = bytes_received + 8'd1;
            if (bytes_received >= 8'd3 && in_body) begin
              if (!d[0]) begin
                held_byte_next = rx_byte;
              end else begin
                q_push      = 1'b1;
                q_cmd.kind  = KIND_WORD;
                q_cmd.value = {held_byte, rx_byte};
                q_cmd.index = d[7:1];
              end
            end else if (p2 == n9) begin
              crc_low_byte_next = rx_byte;
            end else if (p1 == n9) begin
              q_push     = 1'b1;
              q_cmd.kind = KIND_STATUS;
              if (header_bad) begin
                q_cmd.status = ST_HEADER;
              end else if ({rx_byte, crc_low_byte} != running_crc) begin
                q_cmd.status = ST_CRC;
              end else begin
                q_cmd.status = ST_OK;
              end
              waiting_next        = 1'b0;
              bytes_received_next = 8'd0;
            end
          end
        end
        ACT_TICK: begin
          if (waiting) begin
            if (elapsed_ticks >= timeout_ticks) begin
              q_push              = 1'b1;
              q_cmd.kind          = KIND_STATUS;
              q_cmd.status        = ST_TIMEOUT;
              waiting_next        = 1'b0;
              bytes_received_next = 8'd0;
            end else begin
              elapsed_ticks_next = elapsed_ticks + 16'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting         <= 1'b0;
      bytes_received  <= 8'd0;
      expected_length <= 8'd0;
      running_crc     <= CRC_INIT;
      header_bad      <= 1'b0;
      held_byte       <= 8'd0;
      crc_low_byte    <= 8'd0;
      elapsed_ticks   <= 16'd0;
    end else begin
      waiting         <= waiting_next;
      bytes_received  <= bytes_received_next;
      expected_length <= expected_length_next;
      running_crc     <= running_crc_next;
      header_bad      <= header_bad_next;
      held_byte       <= held_byte_next;
      crc_low_byte    <= crc_low_byte_next;
      elapsed_ticks   <= elapsed_ticks_next;
    end
  end

endmodule

// ===== hdl/rdtx_cmdq.sv =====
// ----------------------------------------------------------------------------
// rdtx_cmdq
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module rdtx_cmdq import rdtx_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_push,
  input  cmd_t q_cmd,
  output logic q_full,
  input  logic q_pop,
  output logic q_empty,
  output cmd_t q_head
);

  cmd_t               mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   fill;
  logic               do_push;
  logic               do_pop;

  assign q_full  = fill == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign q_empty = fill == '0;
  assign q_head  = mem[rd_ptr];
  assign do_push = q_push & ~q_full;
  assign do_pop  = q_pop & ~q_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rdtx_back.sv =====
// ----------------------------------------------------------------------------
// rdtx_back
// Expands queued commands into result items; builds request frames and CRC.
// ----------------------------------------------------------------------------
module rdtx_back import rdtx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  kind,
  output logic [15:0] value,
  output logic [6:0]  word_index,
  output logic [1:0]  status,
  output logic        last
);

  back_state_t state, state_next;
  cmd_t        cur, cur_next;
  logic [2:0]  idx, idx_next;
  logic [15:0] crc, crc_next;
  logic        out_valid;
  logic        advance;
  logic        emit;
  logic [7:0]  req_byte;
  logic [1:0]  o_kind;
  logic [15:0] o_value;
  logic [6:0]  o_index;
  logic [1:0]  o_status;
  logic        o_last;

  assign advance = ~out_valid | pop;
  assign empty   = ~out_valid;

  always_comb begin
    case (idx)
      3'd1:    req_byte = FUNC_READ_HOLDING;
      3'd2:    req_byte = cur.value[15:8];
      3'd3:    req_byte = cur.value[7:0];
      3'd5:    req_byte = {1'b0, cur.index};
      3'd6:    req_byte = crc[7:0];
      3'd7:    req_byte = crc[15:8];
      default: req_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_next = state;
    cur_next   = cur;
    idx_next   = idx;
    crc_next   = crc;
    q_pop      = 1'b0;
    emit       = 1'b0;
    o_kind     = KIND_REQ;
    o_value    = 16'd0;
    o_index    = 7'd0;
    o_status   = ST_OK;
    o_last     = 1'b0;
    case (state)
      BK_IDLE: begin
        if (advance && !q_empty) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          if (q_head.kind == KIND_REQ) begin
            o_value    = {8'h00, q_head.addr};
            crc_next   = crc_update(CRC_INIT, q_head.addr);
            cur_next   = q_head;
            idx_next   = 3'd1;
            state_next = BK_REQ;
          end else begin
            o_kind   = q_head.kind;
            o_value  = q_head.value;
            o_index  = q_head.index;
            o_status = q_head.status;
            o_last   = q_head.kind == KIND_STATUS;
          end
        end
      end
      BK_REQ: begin
        if (advance) begin
          emit    = 1'b1;
          o_value = {8'h00, req_byte};
          if (idx <= 3'd5) begin
            crc_next = crc_update(crc, req_byte);
          end
          idx_next = idx + 3'd1;
          if (idx == 3'd7) begin
            o_last     = 1'b1;
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    crc <= crc_next;
    if (emit) begin
      kind       <= o_kind;
      value      <= o_value;
      word_index <= o_index;
      status     <= o_status;
      last       <= o_last;
    end
  end

endmodule

// ===== hdl/modbus_read_transaction.sv =====
// ----------------------------------------------------------------------------
// modbus_read_transaction
// Modbus RTU master for read holding registers (function 3).
// ----------------------------------------------------------------------------
// An item is taken every cycle while full is low. Received bytes and ticks
// each give at most one result. A start gives eight request bytes, which the
// back end sends one per cycle while the output is popped, so a start holds
// the output side until its last byte is sent; the four-entry command queue
// lets the input side keep going meanwhile, and full rises only when that
// queue is full. Data words are provisional until the status item reports ok.
module modbus_read_transaction import rdtx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [15:0] start_register,
  input  logic [6:0]  register_count,
  input  logic [7:0]  rx_byte,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  kind,
  output logic [15:0] value,
  output logic [6:0]  word_index,
  output logic [1:0]  status,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  slave_address;
  logic [15:0] timeout_ticks;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  cmd_t        q_cmd;
  cmd_t        q_head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDRESS_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_SLAVE_ADDRESS: slave_address <= pwdata[7:0];
        REG_TIMEOUT:       timeout_ticks <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SLAVE_ADDRESS: prdata = {24'h000000, slave_address};
      REG_TIMEOUT:       prdata = {16'h0000, timeout_ticks};
      default:           prdata = 32'h00000000;
    endcase
  end

  rdtx_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .action         (action),
    .start_register (start_register),
    .register_count (register_count),
    .rx_byte        (rx_byte),
    .slave_address  (slave_address),
    .timeout_ticks  (timeout_ticks),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  rdtx_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  rdtx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .kind       (kind),
    .value      (value),
    .word_index (word_index),
    .status     (status),
    .last       (last)
  );

endmodule

// ===== hdl/rdtx_checker.sv =====
// ----------------------------------------------------------------------------
// rdtx_checker
// Port-level checks on the result stream and configuration port.
// ----------------------------------------------------------------------------
`include "modbus_read_transaction_macros.svh"

module rdtx_checker import rdtx_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        pop,
  input logic        empty,
  input logic [1:0]  kind,
  input logic [15:0] value,
  input logic [6:0]  word_index,
  input logic [1:0]  status,
  input logic        last,
  input logic        pready
);

  `RDTX_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")
  `RDTX_ASSERT_NOW(a_status_last, !empty && kind == KIND_STATUS, last && value == 16'd0 && word_index == 7'd0, "status item malformed")
  `RDTX_ASSERT_NOW(a_word_not_last, !empty && kind == KIND_WORD, !last && status == ST_OK, "data word malformed")
  `RDTX_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(kind) && $stable(value) && $stable(last), "waiting item changed")

endmodule

bind modbus_read_transaction rdtx_checker u_rdtx_checker (
  .clk        (clk),
  .rst        (rst),
  .pop        (pop),
  .empty      (empty),
  .kind       (kind),
  .value      (value),
  .word_index (word_index),
  .status     (status),
  .last       (last),
  .pready     (pready)
);
